>>> rtl/cba_pkg.sv
// Shared types, constants and codes for the contiguous block allocator.
// No dependencies; every other file of the block refers to it by scoped names.
package cba_pkg;

	localparam int NUM_BLOCKS = 128;
	localparam int IDX_W      = $clog2(NUM_BLOCKS);
	localparam int CNT_W      = IDX_W + 1;

	localparam int LEN_W   = 8;
	localparam int SREQ_W  = 7;
	localparam int START_W = 7;
	localparam int SUM_W   = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 1;

	// APB register map
	localparam int ADDR_W          = 3;
	localparam int DATA_W          = 32;
	localparam int REG_DISK_BLOCKS = 0;
	localparam logic [LEN_W-1:0] DISK_BLOCKS_RESET = 8'd128;

	// result status codes
	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_NOSPACE = 2'd1;
	localparam logic [1:0] ST_BAD     = 2'd2;

	// request kinds
	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	typedef struct packed {
		logic               kind;
		logic [LEN_W-1:0]   length;
		logic [SREQ_W-1:0]  start_req;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [START_W-1:0] alloc_start;
	} rsp_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DECIDE,
		S_SCAN,
		S_APPLY,
		S_FINISH
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic       clear;
		logic       capture;
		logic       scan_step;
		logic       apply;
		logic       set_result;
		logic [1:0] result_status;
		logic       load_out;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic bad;
		logic no_fit;
		logic is_free;
		logic hit;
		logic scan_last;
		logic apply_last;
		logic clear_last;
	} dp_stat_t;

endpackage

>>> rtl/cba_datapath.sv
// Datapath of the block allocator: request registers, used-flag memory with its
// clearing pass, run scanner, range update and result/output registers. Depends on cba_pkg.
module cba_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  cba_pkg::dp_cmd_t            cmd,
	input  cba_pkg::req_t               req,
	input  logic [cba_pkg::LEN_W-1:0]   disk_blocks,
	output cba_pkg::dp_stat_t           stat,
	output cba_pkg::rsp_t               rsp
);

	logic                          kind_q;
	logic [cba_pkg::LEN_W-1:0]     len_q;
	logic [cba_pkg::SREQ_W-1:0]    sreq_q;
	logic [cba_pkg::IDX_W-1:0]     idx_q;
	logic [cba_pkg::CNT_W-1:0]     run_q;
	logic [cba_pkg::CNT_W-1:0]     wcnt_q;
	logic [cba_pkg::IDX_W-1:0]     clr_q;
	logic [cba_pkg::IDX_W-1:0]     start_q;
	logic                          used_mem [cba_pkg::NUM_BLOCKS];
	logic                          used_rd_q;
	cba_pkg::rsp_t                 res_q;
	cba_pkg::rsp_t                 out_q;

	logic [cba_pkg::CNT_W-1:0] size;
	logic [cba_pkg::CNT_W-1:0] run_nx;
	logic [cba_pkg::SUM_W-1:0] hit_start;
	logic [cba_pkg::SUM_W-1:0] lo;
	logic [cba_pkg::IDX_W-1:0] rd_addr;
	logic [cba_pkg::IDX_W-1:0] wr_addr;
	logic                      wr_en;
	logic                      wr_data;

	// usable size: disk_blocks held at the map depth
	assign size = (32'(disk_blocks) > cba_pkg::NUM_BLOCKS) ?
		cba_pkg::CNT_W'(cba_pkg::NUM_BLOCKS) : cba_pkg::CNT_W'(disk_blocks);

	// read one entry ahead while scanning, so used_rd_q holds entry idx_q
	assign rd_addr = cmd.scan_step ? idx_q + 1'b1 : idx_q;

	assign run_nx    = used_rd_q ? '0 : run_q + 1'b1;
	assign hit_start = cba_pkg::SUM_W'(idx_q) + 1'b1 - cba_pkg::SUM_W'(len_q);

	assign lo = (kind_q == cba_pkg::KIND_FREE) ? cba_pkg::SUM_W'(sreq_q)
		: cba_pkg::SUM_W'(start_q);

	// one map write per cycle: clearing pass or range update
	assign wr_en   = cmd.clear || cmd.apply;
	assign wr_addr = cmd.clear ? clr_q : cba_pkg::IDX_W'(lo + cba_pkg::SUM_W'(wcnt_q));
	assign wr_data = !cmd.clear && (kind_q == cba_pkg::KIND_ALLOC);

	always_comb begin
		stat.bad = (len_q == '0) || ((kind_q == cba_pkg::KIND_FREE) &&
			(cba_pkg::SUM_W'(sreq_q) + cba_pkg::SUM_W'(len_q) > cba_pkg::SUM_W'(size)));
		stat.no_fit = (kind_q == cba_pkg::KIND_ALLOC) &&
			(cba_pkg::SUM_W'(len_q) > cba_pkg::SUM_W'(size));
		stat.is_free    = (kind_q == cba_pkg::KIND_FREE);
		stat.hit        = (cba_pkg::SUM_W'(run_nx) == cba_pkg::SUM_W'(len_q));
		stat.scan_last  = (cba_pkg::SUM_W'(idx_q) + 1'b1 == cba_pkg::SUM_W'(size));
		stat.apply_last = (cba_pkg::SUM_W'(wcnt_q) + 1'b1 == cba_pkg::SUM_W'(len_q));
		stat.clear_last = (clr_q == cba_pkg::IDX_W'(cba_pkg::NUM_BLOCKS - 1));
	end

	// used-flag map
	always_ff @(posedge clk) begin
		if (wr_en) begin
			used_mem[wr_addr] <= wr_data;
		end
		used_rd_q <= used_mem[rd_addr];
	end

	// clearing pass address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// request and scan registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= req.kind;
			len_q  <= req.length;
			sreq_q <= req.start_req;
			idx_q  <= '0;
			run_q  <= '0;
			wcnt_q <= '0;
		end else if (cmd.scan_step) begin
			idx_q <= idx_q + 1'b1;
			run_q <= run_nx;
			if (stat.hit) begin
				start_q <= cba_pkg::IDX_W'(hit_start);
			end
		end
		if (cmd.apply) begin
			wcnt_q <= wcnt_q + 1'b1;
		end
		if (cmd.set_result) begin
			res_q.status <= cmd.result_status;
			res_q.alloc_start <= ((cmd.result_status == cba_pkg::ST_DONE) &&
				(kind_q == cba_pkg::KIND_ALLOC)) ? cba_pkg::START_W'(start_q) : '0;
		end
		if (cmd.load_out) begin
			out_q <= res_q;
		end
	end

	assign rsp = out_q;

endmodule

>>> rtl/cba_ctrl.sv
// Controller of the block allocator: sequences clear, decide, scan, apply and
// finish, and owns the response valid flag. Depends on cba_pkg.
module cba_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	input  cba_pkg::dp_stat_t  stat,
	output cba_pkg::dp_cmd_t   cmd
);

	cba_pkg::state_t state_q;
	cba_pkg::state_t state_nx;
	logic            out_valid_q;
	logic            out_free;

	assign out_free = !out_valid_q || rsp_ready;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			cba_pkg::S_CLEAR: begin
				if (stat.clear_last) state_nx = cba_pkg::S_IDLE;
			end
			cba_pkg::S_IDLE: begin
				if (req_valid) state_nx = cba_pkg::S_DECIDE;
			end
			cba_pkg::S_DECIDE: begin
				priority if (stat.bad || stat.no_fit) state_nx = cba_pkg::S_FINISH;
				else if (stat.is_free) state_nx = cba_pkg::S_APPLY;
				else state_nx = cba_pkg::S_SCAN;
			end
			cba_pkg::S_SCAN: begin
				priority if (stat.hit) state_nx = cba_pkg::S_APPLY;
				else if (stat.scan_last) state_nx = cba_pkg::S_FINISH;
				else state_nx = cba_pkg::S_SCAN;
			end
			cba_pkg::S_APPLY: begin
				if (stat.apply_last) state_nx = cba_pkg::S_FINISH;
			end
			cba_pkg::S_FINISH: begin
				if (out_free) state_nx = cba_pkg::S_IDLE;
			end
			default: state_nx = cba_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		req_ready = 1'b0;
		unique case (state_q)
			cba_pkg::S_CLEAR: begin
				cmd.clear = 1'b1;
			end
			cba_pkg::S_IDLE: begin
				req_ready   = 1'b1;
				cmd.capture = req_valid;
			end
			cba_pkg::S_DECIDE: begin
				cmd.set_result = stat.bad || stat.no_fit;
				cmd.result_status = stat.bad ? cba_pkg::ST_BAD : cba_pkg::ST_NOSPACE;
			end
			cba_pkg::S_SCAN: begin
				cmd.scan_step     = 1'b1;
				cmd.set_result    = !stat.hit && stat.scan_last;
				cmd.result_status = cba_pkg::ST_NOSPACE;
			end
			cba_pkg::S_APPLY: begin
				cmd.apply         = 1'b1;
				cmd.set_result    = stat.apply_last;
				cmd.result_status = cba_pkg::ST_DONE;
			end
			cba_pkg::S_FINISH: begin
				cmd.load_out = out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cba_pkg::S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (rsp_ready) out_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = out_valid_q;

endmodule

>>> rtl/contiguous_block_allocator_top.sv
// Top level of the contiguous first-fit block allocator: APB register,
// controller and datapath. Depends on cba_pkg, cba_ctrl and cba_datapath.
//
//   channel   handshake              payload          direction
//   req       req_valid/req_ready    req (req_t)      in
//   rsp       rsp_valid/rsp_ready    rsp (rsp_t)      out
//   apb       psel/penable/pready    paddr/pwdata     in, prdata out
//
// Sequence: a rejected request goes from decide straight to finish; a free
// writes its range into the map one block per cycle, then finishes; an
// allocate scans one block per cycle (the whole usable disk size when no run
// fits, else up to the end of the first fitting window), then writes the range.
// The next request can be taken in the cycle after the result is loaded.
// Reset: a clearing pass writes every map entry free, one per cycle, with
// req_ready low; disk_blocks back to 128.
// Stalls: a finished result waits in the output register; the next request
// is accepted and processed meanwhile, and holds in finish until rsp drains.
module contiguous_block_allocator_top (
	input  logic                          clk,
	input  logic                          arst_n,
	// request channel
	input  logic                          req_valid,
	output logic                          req_ready,
	input  cba_pkg::req_t                 req,
	// response channel
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output cba_pkg::rsp_t                 rsp,
	// configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [cba_pkg::ADDR_W-1:0]    paddr,
	input  logic [cba_pkg::DATA_W-1:0]    pwdata,
	output logic [cba_pkg::DATA_W-1:0]    prdata,
	output logic                          pready
);

	cba_pkg::dp_cmd_t           cmd;
	cba_pkg::dp_stat_t          stat;
	logic [cba_pkg::LEN_W-1:0]  disk_blocks_q;
	logic                       sel_disk_blocks;

	assign pready = 1'b1;

	// one register, word index taken from paddr above the byte offset
	assign sel_disk_blocks =
		(paddr[cba_pkg::ADDR_W-1:2] == (cba_pkg::ADDR_W-2)'(cba_pkg::REG_DISK_BLOCKS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disk_blocks_q <= cba_pkg::DISK_BLOCKS_RESET;
		end else if (psel && penable && pwrite && pready && sel_disk_blocks) begin
			disk_blocks_q <= pwdata[cba_pkg::LEN_W-1:0];
		end
	end

	assign prdata = sel_disk_blocks ? cba_pkg::DATA_W'(disk_blocks_q) : '0;

	cba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	cba_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.req         (req),
		.disk_blocks (disk_blocks_q),
		.stat        (stat),
		.rsp         (rsp)
	);

	// one request in flight: accepting a request closes the input next cycle
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("request accepted while another is in flight");

	// only defined status codes leave the block
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.status == cba_pkg::ST_DONE ||
			rsp.status == cba_pkg::ST_NOSPACE || rsp.status == cba_pkg::ST_BAD))
		else $error("undefined status code on rsp");

	// failed requests report start block zero
	a_fail_start_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status != cba_pkg::ST_DONE) |-> (rsp.alloc_start == '0))
		else $error("nonzero start block on a failed request");

	// the datapath never scans and updates the map in the same cycle
	a_scan_apply_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.scan_step && cmd.apply))
		else $error("scan and map update issued together");

endmodule
